@@ src/bfpa_pkg.sv @@
// shared constants, types and state codes for the best-fit partition allocator
// no dependencies
package bfpa_pkg;

   localparam int MAX_PARTS = 64;
   localparam int SIZE_BITS = 16;
   localparam int IDX_BITS = $clog2(MAX_PARTS);
   localparam int CNT_BITS = $clog2(MAX_PARTS + 1);
   localparam int ENTRY_BITS = 2 * SIZE_BITS + 1;
   localparam logic [15:0] TOTAL_RESET = 16'd640;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_BADSIZE = 2'd2;
   localparam logic [1:0] ST_BADIDX = 2'd3;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_INS_RD,
      S_INS_WR,
      S_SPLIT,
      S_FREE_RD,
      S_FREE_MRG,
      S_REM_RD,
      S_REM_WR,
      S_DONE
   } state_type;

endpackage

@@ src/bfpa_ram.sv @@
// generic simple dual-port synchronous ram (one write port, one read port) with registered read
// no dependencies
module bfpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/best_fit_partition_allocator.sv @@
// best-fit partition allocator top level: sequencer around one partition table ram
// depends on bfpa_pkg and bfpa_ram
//
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_mode/size/index  | in
//  rsp     | rsp_valid rsp_stall rsp_status/base/slot | out
//  csr     | csr_we csr_wdata                         | in
//
// an allocate scans all entries, one ram read a cycle;
// a split adds one read and one write per shifted entry.
// a free that merges shifts the later entries down, one read and one write per entry.
// the table ram port is the limit; one request at a time, the longest being a split
// at slot 0 of a 63-entry table.
// reset or a csr write leaves one free partition; the contents of entries at or above count are never used.
// the response register holds while rsp_stall is high; req_stall is high until the response is taken.
module best_fit_partition_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_request_size,
   input  logic [5:0]  req_part_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_alloc_base,
   output logic [5:0]  rsp_alloc_slot,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int IB = bfpa_pkg::IDX_BITS;
   localparam int CB = bfpa_pkg::CNT_BITS;
   localparam int SB = bfpa_pkg::SIZE_BITS;
   localparam int EB = bfpa_pkg::ENTRY_BITS;

   bfpa_pkg::state_type state_ff, state_in;

   logic [CB-1:0] count_ff, count_in;
   logic [SB-1:0] e0_size_ff;
   logic          e0_busy_ff, e0_busy_in;
   logic [SB-1:0] req_ff;
   logic [IB-1:0] idx_ff, idx_in;
   logic [CB-1:0] ptr_ff, ptr_in;
   logic          found_ff, found_in;
   logic [IB-1:0] best_ff, best_in;
   logic [SB-1:0] bsize_ff, bsize_in;
   logic [SB-1:0] bbase_ff, bbase_in;
   logic [EB-1:0] hold_ff, hold_in;
   logic [1:0]    merge_ff, merge_in;
   logic          rvalid_ff;
   logic [1:0]    rstat_ff, rstat_in;
   logic [15:0]   rbase_ff, rbase_in;
   logic [5:0]    rslot_ff, rslot_in;

   logic          we;
   logic [IB-1:0] waddr, raddr;
   logic [EB-1:0] wdata, rd_raw, rd;
   logic [IB-1:0] rd_addr_ff;
   logic          rd_slot0;

   logic          split_wb_ff;
   logic          we_m;
   logic [IB-1:0] waddr_m;
   logic [EB-1:0] wdata_m;

   bfpa_ram #(.WIDTH(EB), .DEPTH(bfpa_pkg::MAX_PARTS)) u_table (
      .clock(clock), .we(we_m), .waddr(waddr_m), .wdata(wdata_m),
      .raddr(raddr), .rdata(rd_raw)
   );

   // entry 0 after init lives in registers until first written
   logic e0_init_ff, e0_init_in;
   assign rd_slot0 = (rd_addr_ff == '0) && e0_init_ff;
   assign rd = rd_slot0 ? {e0_busy_ff, {SB{1'b0}}, e0_size_ff} : rd_raw;

   wire           rd_busy = rd[EB-1];
   wire [SB-1:0]  rd_base = rd[2*SB-1:SB];
   wire [SB-1:0]  rd_size = rd[SB-1:0];
   wire           req_take = req_valid && !req_stall;
   wire           rsp_take = rvalid_ff && !rsp_stall;
   wire [IB-1:0]  ptr_ix = ptr_ff[IB-1:0];

   assign req_stall = (state_ff != bfpa_pkg::S_IDLE) || csr_we || rvalid_ff;

   always_ff @(posedge clock) begin
      rd_addr_ff <= raddr;
      if (reset) begin
         state_ff   <= bfpa_pkg::S_IDLE;
         count_ff   <= CB'(1);
         e0_size_ff <= SB'(bfpa_pkg::TOTAL_RESET);
         e0_busy_ff <= 1'b0;
         e0_init_ff <= 1'b1;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            count_ff   <= CB'(1);
            e0_size_ff <= SB'(csr_wdata);
            e0_busy_ff <= 1'b0;
            e0_init_ff <= 1'b1;
         end else begin
            count_ff   <= count_in;
            e0_busy_ff <= e0_busy_in;
            e0_init_ff <= e0_init_in;
         end
         if (state_ff == bfpa_pkg::S_DONE) rvalid_ff <= 1'b1;
         else if (rsp_take) rvalid_ff <= 1'b0;
      end
      if (req_take) begin
         req_ff  <= SB'(req_request_size);
      end
      idx_ff   <= idx_in;
      ptr_ff   <= ptr_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bsize_ff <= bsize_in;
      bbase_ff <= bbase_in;
      hold_ff  <= hold_in;
      merge_ff <= merge_in;
      rstat_ff <= rstat_in;
      rbase_ff <= rbase_in;
      rslot_ff <= rslot_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfpa_pkg::S_IDLE:
            if (req_take) begin
               if (req_mode == bfpa_pkg::MODE_FREE) begin
                  state_in = (CB'(req_part_index) < count_ff) ?
                             bfpa_pkg::S_FREE_RD : bfpa_pkg::S_DONE;
               end else begin
                  state_in = (req_request_size == '0) ? bfpa_pkg::S_DONE
                                                      : bfpa_pkg::S_SCAN;
               end
            end
         bfpa_pkg::S_SCAN:
            if (ptr_ff == count_ff) state_in = bfpa_pkg::S_DECIDE;
         bfpa_pkg::S_DECIDE: begin
            if (!found_ff || bsize_ff == req_ff) state_in = bfpa_pkg::S_DONE;
            else if (count_ff == CB'(bfpa_pkg::MAX_PARTS)) state_in = bfpa_pkg::S_DONE;
            else if (count_ff - CB'(1) == CB'(best_ff)) state_in = bfpa_pkg::S_SPLIT;
            else state_in = bfpa_pkg::S_INS_RD;
         end
         bfpa_pkg::S_INS_RD: state_in = bfpa_pkg::S_INS_WR;
         bfpa_pkg::S_INS_WR:
            state_in = (ptr_ff == CB'(best_ff) + CB'(1)) ? bfpa_pkg::S_SPLIT
                                                        : bfpa_pkg::S_INS_RD;
         bfpa_pkg::S_SPLIT: state_in = bfpa_pkg::S_DONE;
         bfpa_pkg::S_FREE_RD:
            if (ptr_ff == CB'(2)) state_in = bfpa_pkg::S_FREE_MRG;
         bfpa_pkg::S_FREE_MRG:
            state_in = (merge_ff == 2'd0) ? bfpa_pkg::S_DONE : bfpa_pkg::S_REM_RD;
         bfpa_pkg::S_REM_RD:
            state_in = (ptr_ff >= count_ff) ? bfpa_pkg::S_DONE
                                            : bfpa_pkg::S_REM_WR;
         bfpa_pkg::S_REM_WR: state_in = bfpa_pkg::S_REM_RD;
         bfpa_pkg::S_DONE:
            if (!rvalid_ff || rsp_take) state_in = bfpa_pkg::S_IDLE;
         default: state_in = bfpa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      e0_busy_in = e0_busy_ff;
      e0_init_in = e0_init_ff;
      idx_in     = idx_ff;
      ptr_in     = ptr_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      bsize_in   = bsize_ff;
      bbase_in   = bbase_ff;
      hold_in    = hold_ff;
      merge_in   = merge_ff;
      rstat_in   = rstat_ff;
      rbase_in   = rbase_ff;
      rslot_in   = rslot_ff;
      we         = 1'b0;
      waddr      = '0;
      wdata      = '0;
      raddr      = ptr_ix;
      case (state_ff)
         bfpa_pkg::S_IDLE: begin
            raddr     = '0;
            ptr_in    = CB'(1);
            found_in  = 1'b0;
            idx_in    = req_part_index[IB-1:0];
            if (req_take) begin
               rstat_in = bfpa_pkg::ST_OK;
               rbase_in = '0;
               rslot_in = '0;
            end
            if (req_mode == bfpa_pkg::MODE_FREE) begin
               raddr  = req_part_index[IB-1:0];
               ptr_in = '0;
               if (req_take && CB'(req_part_index) >= count_ff)
                  rstat_in = bfpa_pkg::ST_BADIDX;
            end else if (req_take && req_request_size == '0) begin
               rstat_in = bfpa_pkg::ST_BADSIZE;
            end
         end
         bfpa_pkg::S_SCAN: begin
            // rd holds entry ptr-1
            if (!rd_busy && rd_size >= req_ff && (!found_ff || rd_size < bsize_ff)) begin
               found_in = 1'b1;
               best_in  = IB'(ptr_ff - CB'(1));
               bsize_in = rd_size;
               bbase_in = rd_base;
            end
            if (ptr_ff != count_ff) ptr_in = ptr_ff + CB'(1);
         end
         bfpa_pkg::S_DECIDE: begin
            ptr_in = count_ff - CB'(1);
            raddr  = IB'(count_ff - CB'(1));
            if (!found_ff) begin
               rstat_in = bfpa_pkg::ST_NOFIT;
            end else if (bsize_ff == req_ff) begin
               we       = 1'b1;
               waddr    = best_ff;
               wdata    = {1'b1, bbase_ff, bsize_ff};
               if (best_ff == '0) e0_init_in = 1'b0;
               rbase_in = 16'(bbase_ff);
               rslot_in = 6'(best_ff);
            end else if (count_ff == CB'(bfpa_pkg::MAX_PARTS)) begin
               rstat_in = bfpa_pkg::ST_BADIDX;
            end
         end
         bfpa_pkg::S_INS_RD: raddr = ptr_ix;
         bfpa_pkg::S_INS_WR: begin
            // copy entry ptr up by one
            we     = 1'b1;
            waddr  = IB'(ptr_ff + CB'(1));
            wdata  = rd;
            ptr_in = ptr_ff - CB'(1);
            raddr  = IB'(ptr_ff - CB'(1));
         end
         bfpa_pkg::S_SPLIT: begin
            we         = 1'b1;
            waddr      = IB'(best_ff + IB'(1));
            wdata      = {1'b0, SB'(bbase_ff + req_ff), SB'(bsize_ff - req_ff)};
            hold_in    = {1'b1, bbase_ff, req_ff};
            count_in   = count_ff + CB'(1);
            rbase_in   = 16'(bbase_ff);
            rslot_in   = 6'(best_ff);
         end
         bfpa_pkg::S_FREE_RD: begin
            // rd returns idx, idx+1, idx-1 in turn; ptr counts reads
            ptr_in = ptr_ff + CB'(1);
            if (ptr_ff == CB'(0)) raddr = IB'(idx_ff + IB'(1));
            else raddr = IB'(idx_ff - IB'(1));
            if (ptr_ff == CB'(0)) begin
               hold_in = {1'b0, rd[2*SB-1:0]};
            end else if (ptr_ff == CB'(1)) begin
               bsize_in    = rd_size;
               merge_in[0] = (CB'(idx_ff) + CB'(1) < count_ff) && !rd_busy;
            end else begin
               merge_in[1] = (idx_ff != '0) && !rd_busy;
            end
         end
         bfpa_pkg::S_FREE_MRG: begin
            // hold: self, bsize: next size, rd: prev entry
            we = 1'b1;
            if (merge_ff[1]) begin
               waddr = idx_ff - IB'(1);
               wdata = {1'b0, rd_base, SB'(rd_size + hold_ff[SB-1:0]
                        + (merge_ff[0] ? bsize_ff : SB'(0)))};
               if (idx_ff == IB'(1)) e0_init_in = 1'b0;
            end else begin
               waddr = idx_ff;
               wdata = {1'b0, hold_ff[2*SB-1:SB], SB'(hold_ff[SB-1:0]
                        + (merge_ff[0] ? bsize_ff : SB'(0)))};
               if (idx_ff == '0) e0_init_in = 1'b0;
            end
            // entries to drop: merge count; shift down from first removed
            ptr_in = merge_ff[1] ? CB'(idx_ff) : CB'(idx_ff) + CB'(1);
            raddr  = IB'((merge_ff[1] ? CB'(idx_ff) : CB'(idx_ff) + CB'(1))
                        + CB'(merge_ff[0] & merge_ff[1]) + CB'(1));
            count_in = count_ff - CB'(merge_ff[0]) - CB'(merge_ff[1]);
            hold_in  = {hold_ff[EB-1:SB], SB'(merge_ff[0] & merge_ff[1])};
         end
         bfpa_pkg::S_REM_RD: begin
            raddr = IB'(ptr_ff + CB'(1) + CB'(hold_ff[0]));
         end
         bfpa_pkg::S_REM_WR: begin
            we     = 1'b1;
            waddr  = ptr_ix;
            wdata  = rd;
            ptr_in = ptr_ff + CB'(1);
            raddr  = IB'(ptr_ff + CB'(2) + CB'(hold_ff[0]));
         end
         bfpa_pkg::S_DONE: ;
         default: ;
      endcase
      if (state_ff == bfpa_pkg::S_SPLIT && best_ff == '0) e0_init_in = 1'b0;
      if (state_ff == bfpa_pkg::S_REM_WR && ptr_ix == '0) e0_init_in = 1'b0;
   end

   // split writes the busy low piece from a register in the following cycle, while in done
   always_ff @(posedge clock) begin
      if (reset) split_wb_ff <= 1'b0;
      else split_wb_ff <= (state_ff == bfpa_pkg::S_SPLIT);
   end

   assign we_m    = we || split_wb_ff;
   assign waddr_m = split_wb_ff ? best_ff : waddr;
   assign wdata_m = split_wb_ff ? hold_ff : wdata;

   assign rsp_valid      = rvalid_ff;
   assign rsp_status     = rstat_ff;
   assign rsp_alloc_base = rbase_ff;
   assign rsp_alloc_slot = rslot_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CB'(bfpa_pkg::MAX_PARTS))
      else $error("partition count out of range");
   a_busy_when_resp: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> req_stall || state_ff == bfpa_pkg::S_IDLE)
      else $error("request taken while busy");
   a_done_to_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfpa_pkg::S_DONE && !rvalid_ff |=> rvalid_ff)
      else $error("response lost");
   a_split_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == bfpa_pkg::S_SPLIT && !csr_we |=> count_ff == $past(count_ff) + CB'(1))
      else $error("split did not grow table");
`endif

endmodule
